>>> hw/rtl/addressable_led_strip_encoder_core_assert.svh
// assertion macros used by the led strip encoder core rtl
`ifndef ADDRESSABLE_LED_STRIP_ENCODER_CORE_ASSERT_SVH
`define ADDRESSABLE_LED_STRIP_ENCODER_CORE_ASSERT_SVH

// same-cycle implication, checked outside reset
`define ALESC_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("alesc check failed");

// next-cycle implication, checked outside reset
`define ALESC_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("alesc check failed");

`endif

>>> hw/rtl/alesc_pkg.sv
// shared types, constants and helpers for the led strip encoder
`timescale 1ns / 1ps

package alesc_pkg;

    localparam int PIXEL_BITS    = 24;
    localparam int BIT_CNT_W     = 5;
    localparam int TICK_W        = 8;
    localparam int SEL_W         = 3;
    localparam int STORE_MAX     = 1 << SEL_W;
    localparam int LED_COUNT_DEF = 8;
    localparam int APB_ADDR_W    = 4;
    localparam int APB_DATA_W    = 32;

    // item function codes
    localparam logic [1:0] FUNC_WRITE = 2'd0;
    localparam logic [1:0] FUNC_START = 2'd1;
    localparam logic [1:0] FUNC_TICK  = 2'd2;

    // register indexes
    localparam logic [1:0] REG_ZERO_HIGH = 2'd0;
    localparam logic [1:0] REG_ONE_HIGH  = 2'd1;
    localparam logic [1:0] REG_LOW_GAP   = 2'd2;

    localparam logic [TICK_W-1:0] ZERO_HIGH_RST = 8'd8;
    localparam logic [TICK_W-1:0] ONE_HIGH_RST  = 8'd40;
    localparam logic [TICK_W-1:0] LOW_GAP_RST   = 8'd8;

    typedef struct packed {
        logic [1:0]       func;
        logic [SEL_W-1:0] led_select;
        logic [7:0]       red;
        logic [7:0]       green;
        logic [7:0]       blue;
    } item_t;

    typedef struct packed {
        logic pin_level;
        logic busy_res;
        logic frame_done;
    } result_t;

    typedef struct packed {
        logic [TICK_W-1:0] zero_high_ticks;
        logic [TICK_W-1:0] one_high_ticks;
        logic [TICK_W-1:0] low_gap_ticks;
    } timing_cfg_t;

    // a zero length counts as one tick
    function automatic logic [TICK_W-1:0] at_least_one(input logic [TICK_W-1:0] v);
        return (v == '0) ? TICK_W'(1) : v;
    endfunction

endpackage

>>> hw/rtl/addressable_led_strip_encoder_core.sv
// top level of the one-wire led strip encoder
`timescale 1ns / 1ps

// items pass the input register, then the result register; one item per cycle while
// results are taken, set by the single pass from input to result register
// each tick item advances the pin waveform by one time unit
// reset (aresetn low, synchronous): idle, pin low, colour store cleared,
// timing registers back to 8 / 40 / 8 ticks

module addressable_led_strip_encoder_core import alesc_pkg::*; #(
    parameter int LED_COUNT = LED_COUNT_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // item input channel
    input  logic                  s_valid,
    output logic                  s_ready,
    input  item_t                 s_data,
    // result channel
    output logic                  m_valid,
    input  logic                  m_ready,
    output result_t               m_data,
    // register port
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    `include "addressable_led_strip_encoder_core_assert.svh"

    localparam int LED_IDX_W = (LED_COUNT > 1) ? $clog2(LED_COUNT) : 1;
    localparam logic [LED_IDX_W-1:0] LAST_LED = LED_IDX_W'(LED_COUNT - 1);

    // timing registers
    timing_cfg_t cfg;

    alesc_cfg_regs u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // input register and result register with a shared stall
    item_t   item_reg;
    logic    in_valid_reg;
    result_t out_reg;
    result_t out_next;
    logic    out_valid_reg;
    logic    advance;

    // the item in the input register moves on when the result slot is free or draining
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;
    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            item_reg <= s_data;
        end
    end

    // frame state
    logic [PIXEL_BITS-1:0]  shift_word_reg,    shift_word_next;
    logic [BIT_CNT_W-1:0]   bit_count_reg,     bit_count_next;
    logic [LED_IDX_W-1:0]   led_count_reg,     led_count_next;
    logic [TICK_W-1:0]      phase_ticks_reg,   phase_ticks_next;
    logic                   in_high_phase_reg, in_high_phase_next;
    logic                   sending_reg,       sending_next;

    logic [LED_IDX_W-1:0]   next_led;
    logic [LED_IDX_W-1:0]   rd_idx;
    logic [PIXEL_BITS-1:0]  load_colour;
    logic [TICK_W-1:0]      phase_dec;
    logic                   store_wr;
    logic                   done;

    assign next_led = led_count_reg + LED_IDX_W'(1);
    // a start loads the first led, a tick may load the following one
    assign rd_idx   = (item_reg.func == FUNC_START) ? '0 : next_led;
    // writes only land while no frame is going out
    assign store_wr = advance && (item_reg.func == FUNC_WRITE) && !sending_reg;

    alesc_colour_store #(
        .LED_COUNT (LED_COUNT),
        .LED_IDX_W (LED_IDX_W)
    ) u_store (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .wr_en     (store_wr),
        .wr_sel    (item_reg.led_select),
        .wr_colour ({item_reg.red, item_reg.green, item_reg.blue}),
        .rd_idx    (rd_idx),
        .rd_colour (load_colour)
    );

    // phase counter with a floor at zero
    assign phase_dec = (phase_ticks_reg != '0) ? phase_ticks_reg - TICK_W'(1) : '0;

    always_comb begin
        shift_word_next    = shift_word_reg;
        bit_count_next     = bit_count_reg;
        led_count_next     = led_count_reg;
        phase_ticks_next   = phase_ticks_reg;
        in_high_phase_next = in_high_phase_reg;
        sending_next       = sending_reg;
        done               = 1'b0;

        unique case (item_reg.func)
            FUNC_START: begin
                // start: load led 0 and raise the pin for its msb
                if (!sending_reg) begin
                    sending_next       = 1'b1;
                    led_count_next     = '0;
                    shift_word_next    = load_colour;
                    bit_count_next     = BIT_CNT_W'(PIXEL_BITS - 1);
                    in_high_phase_next = 1'b1;
                    phase_ticks_next   = load_colour[PIXEL_BITS-1] ?
                                         at_least_one(cfg.one_high_ticks) :
                                         at_least_one(cfg.zero_high_ticks);
                end
            end
            FUNC_TICK: begin
                if (sending_reg) begin
                    if (phase_dec != '0) begin
                        phase_ticks_next = phase_dec;
                    end else if (in_high_phase_reg) begin
                        // high pulse over, go into the low gap
                        in_high_phase_next = 1'b0;
                        phase_ticks_next   = at_least_one(cfg.low_gap_ticks);
                    end else if (bit_count_reg != '0) begin
                        // gap over, next bit of the same led
                        bit_count_next     = bit_count_reg - BIT_CNT_W'(1);
                        shift_word_next    = {shift_word_reg[PIXEL_BITS-2:0], 1'b0};
                        in_high_phase_next = 1'b1;
                        phase_ticks_next   = shift_word_reg[PIXEL_BITS-2] ?
                                             at_least_one(cfg.one_high_ticks) :
                                             at_least_one(cfg.zero_high_ticks);
                    end else if (led_count_reg != LAST_LED) begin
                        // gap over, first bit of the next led
                        led_count_next     = next_led;
                        shift_word_next    = load_colour;
                        bit_count_next     = BIT_CNT_W'(PIXEL_BITS - 1);
                        in_high_phase_next = 1'b1;
                        phase_ticks_next   = load_colour[PIXEL_BITS-1] ?
                                             at_least_one(cfg.one_high_ticks) :
                                             at_least_one(cfg.zero_high_ticks);
                    end else begin
                        // last gap of the last led ends the frame
                        sending_next       = 1'b0;
                        in_high_phase_next = 1'b0;
                        phase_ticks_next   = '0;
                        done               = 1'b1;
                    end
                end
            end
            default: ; // writes only touch the store, unused code does nothing
        endcase

        out_next.pin_level  = sending_next && in_high_phase_next;
        out_next.busy_res   = sending_next;
        out_next.frame_done = done;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            shift_word_reg    <= '0;
            bit_count_reg     <= '0;
            led_count_reg     <= '0;
            phase_ticks_reg   <= '0;
            in_high_phase_reg <= 1'b0;
            sending_reg       <= 1'b0;
        end else if (advance) begin
            shift_word_reg    <= shift_word_next;
            bit_count_reg     <= bit_count_next;
            led_count_reg     <= led_count_next;
            phase_ticks_reg   <= phase_ticks_next;
            in_high_phase_reg <= in_high_phase_next;
            sending_reg       <= sending_next;
        end
    end

    // result register: holds until taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_reg <= out_next;
        end
    end

    // checks
    `ALESC_ASSERT_NOW(a_done_ends_frame, aclk, aresetn,
        out_valid_reg && out_reg.frame_done, !out_reg.busy_res && !out_reg.pin_level)
    `ALESC_ASSERT_NOW(a_pin_needs_busy, aclk, aresetn,
        out_valid_reg && out_reg.pin_level, out_reg.busy_res)
    `ALESC_ASSERT_NOW(a_phase_live, aclk, aresetn,
        sending_reg, phase_ticks_reg != '0)
    `ALESC_ASSERT_NEXT(a_idle_write_frozen, aclk, aresetn,
        !sending_reg && advance && (item_reg.func != FUNC_START), !sending_reg)

endmodule

>>> hw/rtl/alesc_cfg_regs.sv
// apb register block for the pulse timing registers
`timescale 1ns / 1ps

module alesc_cfg_regs import alesc_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    output timing_cfg_t           cfg
);

    timing_cfg_t cfg_reg;
    logic [1:0]  reg_idx;
    logic        wr_en;

    assign pready  = 1'b1;
    assign reg_idx = paddr[3:2];
    assign wr_en   = psel && penable && pwrite;
    assign cfg     = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.zero_high_ticks <= ZERO_HIGH_RST;
            cfg_reg.one_high_ticks  <= ONE_HIGH_RST;
            cfg_reg.low_gap_ticks   <= LOW_GAP_RST;
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_ZERO_HIGH: cfg_reg.zero_high_ticks <= pwdata[TICK_W-1:0];
                REG_ONE_HIGH:  cfg_reg.one_high_ticks  <= pwdata[TICK_W-1:0];
                REG_LOW_GAP:   cfg_reg.low_gap_ticks   <= pwdata[TICK_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_ZERO_HIGH: prdata = APB_DATA_W'(cfg_reg.zero_high_ticks);
            REG_ONE_HIGH:  prdata = APB_DATA_W'(cfg_reg.one_high_ticks);
            REG_LOW_GAP:   prdata = APB_DATA_W'(cfg_reg.low_gap_ticks);
            default:       prdata = '0;
        endcase
    end

endmodule

>>> hw/rtl/alesc_colour_store.sv
// per-led colour store, cleared at reset
`timescale 1ns / 1ps

module alesc_colour_store import alesc_pkg::*; #(
    parameter int LED_COUNT = LED_COUNT_DEF,
    parameter int LED_IDX_W = 3
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  wr_en,
    input  logic [SEL_W-1:0]      wr_sel,
    input  logic [PIXEL_BITS-1:0] wr_colour,
    input  logic [LED_IDX_W-1:0]  rd_idx,
    output logic [PIXEL_BITS-1:0] rd_colour
);

    // only the first STORE_DEPTH leds (at most eight) can ever be written, the rest read as black
    localparam int STORE_DEPTH = (LED_COUNT < STORE_MAX) ? LED_COUNT : STORE_MAX;
    localparam int STORE_W     = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;

    logic [PIXEL_BITS-1:0] store_reg [STORE_DEPTH];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < STORE_DEPTH; i++) begin
                store_reg[i] <= '0;
            end
        end else if (wr_en && (int'(wr_sel) < STORE_DEPTH)) begin
            store_reg[wr_sel[STORE_W-1:0]] <= wr_colour;
        end
    end

    assign rd_colour = (int'(rd_idx) < STORE_DEPTH) ? store_reg[rd_idx[STORE_W-1:0]] : '0;

endmodule

>>> tb/addressable_led_strip_encoder_core_tb.sv
// self-checking testbench for the one-wire led strip encoder core
`timescale 1ns / 1ps

module addressable_led_strip_encoder_core_tb;
    import alesc_pkg::*;

    localparam int CLK_HALF        = 2;
    localparam int RESET_CYCLES    = 12;
    localparam int LED_TOTAL       = LED_COUNT_DEF;
    localparam int PHASE_COUNT     = 10;
    localparam int HOLD_PHASE      = 4;
    localparam int HOLD_OFF_CYCLES = 80;
    localparam int DRAIN_CYCLES    = 4;
    localparam int CYCLE_LIMIT     = 400000;

    // codes the package leaves unnamed
    localparam logic [1:0] FUNC_NONE  = 2'd3;
    localparam logic [1:0] REG_UNUSED = 2'd3;

    // results that can be read straight off the waveform rules
    localparam result_t RES_IDLE  = 3'b000;
    localparam result_t RES_PULSE = 3'b110;

    logic                  aclk;
    logic                  aresetn;
    logic                  s_valid;
    logic                  s_ready;
    item_t                 s_data;
    logic                  m_valid;
    logic                  m_ready;
    result_t               m_data;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    addressable_led_strip_encoder_core DUT (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // free-running clock
    initial aclk = 1'b0;
    always #CLK_HALF aclk = ~aclk;

    // ------------------------------------------------------------------
    // waveform predictor: own copy of the colour store, timing and frame state
    // ------------------------------------------------------------------
    timing_cfg_t       line_timing;
    logic [23:0]       colour_mem [LED_TOTAL];
    logic [23:0]       shift_word;
    logic [4:0]        bit_idx;
    logic [SEL_W-1:0]  led_idx;
    logic [TICK_W-1:0] phase_left;
    logic              high_phase;
    logic              frame_active;

    // results still owed by the block, oldest first
    result_t line_results_due [$];

    typedef struct {
        item_t   stim;
        bit      fixed;
        result_t want;
    } dir_row_t;

    dir_row_t directed_rows [$];

    int error_count;
    int cycle_count;
    bit calm_phase;
    bit hold_off_request;
    bit receiver_holding;

    // load the high pulse for the current bit, zero length counts as one tick
    function automatic void start_bit();
        logic [TICK_W-1:0] len;
        len = shift_word[bit_idx] ? line_timing.one_high_ticks
                                  : line_timing.zero_high_ticks;
        high_phase = 1'b1;
        phase_left = (len == '0) ? TICK_W'(1) : len;
    endfunction

    // fetch an led's colour word, msb goes out first
    function automatic void load_led(input int idx);
        led_idx    = SEL_W'(idx);
        shift_word = colour_mem[idx];
        bit_idx    = 5'(PIXEL_BITS - 1);
        start_bit();
    endfunction

    // advance the predictor by one item and return the line state after it
    function automatic result_t encode_item(input item_t it);
        result_t r;
        logic    done;
        done = 1'b0;
        case (it.func)
            FUNC_WRITE: begin
                // writes during a frame are dropped
                if (!frame_active)
                    colour_mem[it.led_select] = {it.red, it.green, it.blue};
            end
            FUNC_START: begin
                // a start during a frame is dropped, otherwise the pin rises at once
                if (!frame_active) begin
                    frame_active = 1'b1;
                    load_led(0);
                end
            end
            FUNC_TICK: begin
                if (frame_active) begin
                    if (phase_left != '0)
                        phase_left = phase_left - 1'b1;
                    if (phase_left == '0) begin
                        if (high_phase) begin
                            // pulse over, low gap follows
                            high_phase = 1'b0;
                            phase_left = (line_timing.low_gap_ticks == '0) ? TICK_W'(1)
                                                                          : line_timing.low_gap_ticks;
                        end else if (bit_idx != '0) begin
                            bit_idx = bit_idx - 1'b1;
                            start_bit();
                        end else if (int'(led_idx) + 1 < LED_TOTAL) begin
                            load_led(int'(led_idx) + 1);
                        end else begin
                            // last gap of the last led closes the frame
                            frame_active = 1'b0;
                            high_phase   = 1'b0;
                            phase_left   = '0;
                            done         = 1'b1;
                        end
                    end
                end
            end
            default: ;  // unused code leaves the predictor unchanged
        endcase
        r.pin_level  = frame_active && high_phase;
        r.busy_res   = frame_active;
        r.frame_done = done;
        return r;
    endfunction

    // random item, mostly well-formed: fill and start when idle, tick while sending
    function automatic item_t draw_item();
        item_t it;
        int    pick;
        it.led_select = SEL_W'($urandom_range(0, STORE_MAX - 1));
        it.red        = 8'($urandom_range(0, 255));
        it.green      = 8'($urandom_range(0, 255));
        it.blue       = 8'($urandom_range(0, 255));
        pick          = $urandom_range(0, 99);
        if (!frame_active)
            it.func = (pick < 70) ? FUNC_WRITE : (pick < 90) ? FUNC_START :
                      (pick < 98) ? FUNC_TICK : FUNC_NONE;
        else
            it.func = (pick < 90) ? FUNC_TICK : (pick < 94) ? FUNC_WRITE :
                      (pick < 97) ? FUNC_START : FUNC_NONE;
        return it;
    endfunction

    function automatic void add_row(input logic [1:0] func, input logic [SEL_W-1:0] sel,
                                    input logic [7:0] r, input logic [7:0] g,
                                    input logic [7:0] b, input bit fixed, input result_t want);
        dir_row_t row;
        row.stim  = {func, sel, r, g, b};
        row.fixed = fixed;
        row.want  = want;
        directed_rows.push_back(row);
    endfunction

    task automatic flag_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $time, msg);
        error_count++;
    endtask

    // ------------------------------------------------------------------
    // item sender: holds valid and payload until the handshake, then predicts
    // ------------------------------------------------------------------
    task automatic send_item(input item_t it, input bit fixed, input result_t want);
        result_t predicted;
        s_data  <= it;
        s_valid <= 1'b1;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        predicted = encode_item(it);
        // typed rows still advance the predictor but check against the typed value
        line_results_due.push_back(fixed ? want : predicted);
    endtask

    // random idle bursts on the input side, none in the calm phase or during a hold-off
    task automatic pace_sender();
        if (!calm_phase && !receiver_holding && !hold_off_request &&
            $urandom_range(0, 9) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge aclk);
        end
    endtask

    // stop offering items and wait until every owed result is in
    task automatic settle_pipeline();
        s_valid <= 1'b0;
        while (line_results_due.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // register port: setup phase, then access phase, then the bus goes idle
    task automatic write_timing_reg(input logic [1:0] idx, input logic [TICK_W-1:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= APB_ADDR_W'({idx, 2'b00});
        pwdata  <= APB_DATA_W'(val);
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_ZERO_HIGH: line_timing.zero_high_ticks = val;
            REG_ONE_HIGH:  line_timing.one_high_ticks  = val;
            REG_LOW_GAP:   line_timing.low_gap_ticks   = val;
            default: ;  // no register there
        endcase
        @(posedge aclk);
    endtask

    task automatic check_timing_reg(input logic [1:0] idx, input logic [TICK_W-1:0] want);
        logic [TICK_W-1:0] got;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= APB_ADDR_W'({idx, 2'b00});
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        got     = prdata[TICK_W-1:0];
        psel    <= 1'b0;
        penable <= 1'b0;
        if (got !== want)
            flag_mismatch($sformatf("register %0d reads %0d, want %0d", idx, got, want));
        @(posedge aclk);
    endtask

    // new pulse and gap lengths, written only with nothing in flight
    task automatic apply_timing(input logic [TICK_W-1:0] zh, input logic [TICK_W-1:0] oh,
                                input logic [TICK_W-1:0] gap);
        settle_pipeline();
        write_timing_reg(REG_ZERO_HIGH, zh);
        write_timing_reg(REG_ONE_HIGH, oh);
        write_timing_reg(REG_LOW_GAP, gap);
        check_timing_reg(REG_ZERO_HIGH, line_timing.zero_high_ticks);
        check_timing_reg(REG_ONE_HIGH, line_timing.one_high_ticks);
        check_timing_reg(REG_LOW_GAP, line_timing.low_gap_ticks);
    endtask

    // ------------------------------------------------------------------
    // result receiver: random stall bursts plus one long hold-off on request
    // ------------------------------------------------------------------
    initial begin
        m_ready <= 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            @(posedge aclk);
            if (hold_off_request) begin
                // hold long enough for the block to fill up and push back on its input
                hold_off_request = 1'b0;
                receiver_holding = 1'b1;
                m_ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge aclk);
                m_ready <= 1'b1;
                receiver_holding = 1'b0;
            end else if (!calm_phase && $urandom_range(0, 7) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 17)) @(posedge aclk);
                m_ready <= 1'b1;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // compare every accepted result with the oldest owed one
    always @(posedge aclk) begin
        result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (line_results_due.size() == 0) begin
                flag_mismatch("result with nothing pending");
            end else begin
                want = line_results_due.pop_front();
                if (m_data.pin_level !== want.pin_level)
                    flag_mismatch($sformatf("pin_level %b, want %b",
                                            m_data.pin_level, want.pin_level));
                if (m_data.busy_res !== want.busy_res)
                    flag_mismatch($sformatf("busy_res %b, want %b",
                                            m_data.busy_res, want.busy_res));
                if (m_data.frame_done !== want.frame_done)
                    flag_mismatch($sformatf("frame_done %b, want %b",
                                            m_data.frame_done, want.frame_done));
            end
        end
    end

    // run guard
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("addressable_led_strip_encoder_core_tb: done, errors");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------
    initial begin
        int                phase;
        int                run_len;
        logic [TICK_W-1:0] zh;
        logic [TICK_W-1:0] oh;
        logic [TICK_W-1:0] gap;

        error_count      = 0;
        cycle_count      = 0;
        calm_phase       = 1'b0;
        hold_off_request = 1'b0;
        receiver_holding = 1'b0;

        // predictor at its reset state
        line_timing = {ZERO_HIGH_RST, ONE_HIGH_RST, LOW_GAP_RST};
        for (int i = 0; i < LED_TOTAL; i++)
            colour_mem[i] = '0;
        shift_word   = '0;
        bit_idx      = '0;
        led_idx      = '0;
        phase_left   = '0;
        high_phase   = 1'b0;
        frame_active = 1'b0;

        // every input known from time zero
        aresetn <= 1'b0;
        s_valid <= 1'b0;
        s_data  <= '0;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= '0;
        pwdata  <= '0;

        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // timing registers come out of reset at 8 / 40 / 8
        check_timing_reg(REG_ZERO_HIGH, ZERO_HIGH_RST);
        check_timing_reg(REG_ONE_HIGH, ONE_HIGH_RST);
        check_timing_reg(REG_LOW_GAP, LOW_GAP_RST);

        // directed rows at reset timing
        // tick and unused code while idle: nothing moves, pin low
        add_row(FUNC_TICK,  3'd0, 8'h00, 8'h00, 8'h00, 1'b1, RES_IDLE);
        add_row(FUNC_NONE,  3'd7, 8'hff, 8'hff, 8'hff, 1'b1, RES_IDLE);
        // colour extremes at both ends of the strip, plus two mixed colours
        add_row(FUNC_WRITE, 3'd0, 8'hff, 8'hff, 8'hff, 1'b1, RES_IDLE);
        add_row(FUNC_WRITE, 3'd7, 8'h00, 8'h00, 8'h00, 1'b1, RES_IDLE);
        add_row(FUNC_WRITE, 3'd3, 8'h80, 8'h01, 8'ha5, 1'b1, RES_IDLE);
        add_row(FUNC_WRITE, 3'd1, 8'h00, 8'h00, 8'h01, 1'b1, RES_IDLE);
        // start raises the pin at once, first bit is a one
        add_row(FUNC_START, 3'd0, 8'h00, 8'h00, 8'h00, 1'b1, RES_PULSE);
        // start, write and unused code during the frame are dropped
        add_row(FUNC_START, 3'd0, 8'h00, 8'h00, 8'h00, 1'b1, RES_PULSE);
        add_row(FUNC_WRITE, 3'd0, 8'h00, 8'h00, 8'h00, 1'b1, RES_PULSE);
        add_row(FUNC_NONE,  3'd2, 8'h55, 8'haa, 8'h0f, 1'b1, RES_PULSE);
        // a few ticks into the long pulse
        for (int i = 0; i < 8; i++)
            add_row(FUNC_TICK, SEL_W'(i), 8'(i), 8'hff, 8'h00, 1'b0, RES_IDLE);
        add_row(FUNC_WRITE, 3'd5, 8'h12, 8'h34, 8'h56, 1'b0, RES_IDLE);

        foreach (directed_rows[i]) begin
            send_item(directed_rows[i].stim, directed_rows[i].fixed, directed_rows[i].want);
            pace_sender();
        end

        // random phases; the first timing change lands mid-frame with zero lengths
        for (phase = 0; phase < PHASE_COUNT; phase++) begin
            case (phase)
                0: begin
                    zh  = 8'd0;
                    oh  = 8'd0;
                    gap = 8'd0;
                end
                1: begin
                    zh  = 8'd1;
                    oh  = 8'd1;
                    gap = 8'd1;
                end
                PHASE_COUNT - 2: begin
                    // slowest setting, kept short
                    zh  = 8'd255;
                    oh  = 8'd255;
                    gap = 8'd255;
                end
                default: begin
                    zh  = ($urandom_range(0, 3) == 0) ? 8'd0 : 8'($urandom_range(1, 2));
                    oh  = ($urandom_range(0, 3) == 0) ? 8'd0 : 8'($urandom_range(1, 2));
                    gap = ($urandom_range(0, 3) == 0) ? 8'd0 : 8'($urandom_range(1, 2));
                end
            endcase
            run_len    = (phase == PHASE_COUNT - 2) ? 40 : 160;
            calm_phase = (phase == PHASE_COUNT - 1);
            apply_timing(zh, oh, gap);
            // write past the last register must not disturb anything
            if (phase == 0)
                write_timing_reg(REG_UNUSED, 8'hff);
            // long receiver hold-off while items keep coming
            if (phase == HOLD_PHASE)
                hold_off_request = 1'b1;
            repeat (run_len) begin
                send_item(draw_item(), 1'b0, RES_IDLE);
                pace_sender();
            end
        end

        settle_pipeline();
        if (error_count == 0)
            $display("addressable_led_strip_encoder_core_tb: done, clean");
        else
            $display("addressable_led_strip_encoder_core_tb: done, errors");
        $finish;
    end

endmodule

>>> files.f
+incdir+hw/rtl
hw/rtl/alesc_pkg.sv
hw/rtl/alesc_cfg_regs.sv
hw/rtl/alesc_colour_store.sv
hw/rtl/addressable_led_strip_encoder_core.sv
tb/addressable_led_strip_encoder_core_tb.sv
